// ----- rtl/bmpdec_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Shared types and constants of the 24-bit BMP stream decoder: the image size
// limit, counter widths, result status codes and the result item record.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

   localparam int MAX_DIM = 4096;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int COORD_W = 12;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int CNT_W   = (DIM_W > COORD_W) ? DIM_W : COORD_W;

   typedef enum logic [1:0] {
      STATUS_PIXEL         = 2'd0,
      STATUS_BAD_SIGNATURE = 2'd1,
      STATUS_BAD_DEPTH     = 2'd2,
      STATUS_TOO_LARGE     = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  red;
      logic [BYTE_W-1:0]  green;
      logic [BYTE_W-1:0]  blue;
      logic [COORD_W-1:0] pixel_column;
      logic [COORD_W-1:0] pixel_row;
      logic               last_pixel;
      status_type         status;
   } rsp_item_type;

   typedef struct packed {
      logic         push;
      rsp_item_type item;
   } queue_write_type;

endpackage : bmpdec_pkg
`default_nettype wire

// ----- rtl/bmpdec_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_front
// Front end of the decoder. Parses the 54-byte header, assembles pixels from
// blue, green, red byte triples, skips row padding and pushes one result item
// per pixel or per header error into the result queue.
// ----------------------------------------------------------------------------
module bmpdec_front
   import bmpdec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [BYTE_W-1:0] byte_value,
   input  wire logic              start_of_file,
   output queue_write_type        queue_write
);

   localparam int POS_W        = 6;
   localparam int HEADER_BYTES = 54;
   localparam int POS_SIG0     = 0;
   localparam int POS_SIG1     = 1;
   localparam int POS_WIDTH    = 18;
   localparam int POS_HEIGHT   = 22;
   localparam int POS_DEPTH_LO = 28;
   localparam int POS_DEPTH_HI = 29;
   localparam int LANES        = 4;

   localparam logic [BYTE_W-1:0]   LETTER_B  = BYTE_W'(66);
   localparam logic [BYTE_W-1:0]   LETTER_M  = BYTE_W'(77);
   localparam logic [2*BYTE_W-1:0] DEPTH_24  = (2*BYTE_W)'(24);
   localparam logic [WORD_W-1:0]   DIM_LIMIT = WORD_W'(MAX_DIM);

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PIXELS,
      PH_PADDING,
      PH_IDLE
   } phase_type;

   phase_type          phase_ff, phase_in, phase_cur;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_cur;
   logic [BYTE_W-1:0]  letter_ff, letter_in;
   logic [WORD_W-1:0]  width_ff, width_in, width_cur;
   logic [WORD_W-1:0]  height_ff, height_in, height_cur;
   logic [BYTE_W-1:0]  depth_lo_ff, depth_lo_in;
   logic [CNT_W-1:0]   col_ff, col_in, col_cur;
   logic [CNT_W-1:0]   row_ff, row_in, row_cur;
   logic [1:0]         chan_ff, chan_in, chan_cur;
   logic [BYTE_W-1:0]  blue_ff, blue_in;
   logic [BYTE_W-1:0]  green_ff, green_in;
   logic [1:0]         pad_ff, pad_in, pad_cur;
   queue_write_type    write_in;

   logic [CNT_W-1:0]   col_next;
   logic [CNT_W-1:0]   row_next;
   logic               is_last;
   logic               header_error;
   status_type         error_status;

   always_comb begin
      phase_cur  = start_of_file ? PH_HEADER : phase_ff;
      pos_cur    = start_of_file ? '0 : pos_ff;
      width_cur  = start_of_file ? '0 : width_ff;
      height_cur = start_of_file ? '0 : height_ff;
      col_cur    = start_of_file ? '0 : col_ff;
      row_cur    = start_of_file ? '0 : row_ff;
      chan_cur   = start_of_file ? '0 : chan_ff;
      pad_cur    = start_of_file ? '0 : pad_ff;

      col_next = col_cur + 1'b1;
      row_next = row_cur + 1'b1;
      is_last  = (row_next == height_cur[CNT_W-1:0]) && (col_next == width_cur[CNT_W-1:0]);

      phase_in    = phase_ff;
      pos_in      = pos_ff;
      letter_in   = letter_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      depth_lo_in = depth_lo_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      chan_in     = chan_ff;
      blue_in     = blue_ff;
      green_in    = green_ff;
      pad_in      = pad_ff;
      write_in    = '0;
      header_error = 1'b0;
      error_status = STATUS_PIXEL;

      if (accept) begin
         phase_in  = phase_cur;
         pos_in    = pos_cur;
         width_in  = width_cur;
         height_in = height_cur;
         col_in    = col_cur;
         row_in    = row_cur;
         chan_in   = chan_cur;
         pad_in    = pad_cur;

         case (phase_cur)
            PH_HEADER: begin
               pos_in = pos_cur + 1'b1;
               if (pos_cur == POS_W'(POS_SIG0)) begin
                  letter_in = byte_value;
               end
               if (pos_cur == POS_W'(POS_SIG1)) begin
                  if (letter_ff != LETTER_B || byte_value != LETTER_M) begin
                     header_error = 1'b1;
                     error_status = STATUS_BAD_SIGNATURE;
                  end
               end
               for (int k = 0; k < LANES; k++) begin
                  if (pos_cur == POS_W'(POS_WIDTH + k)) begin
                     width_in[BYTE_W*k +: BYTE_W] = byte_value;
                  end
                  if (pos_cur == POS_W'(POS_HEIGHT + k)) begin
                     height_in[BYTE_W*k +: BYTE_W] = byte_value;
                  end
               end
               if (pos_cur == POS_W'(POS_DEPTH_LO)) begin
                  depth_lo_in = byte_value;
               end
               if (pos_cur == POS_W'(POS_DEPTH_HI)) begin
                  if ({byte_value, depth_lo_ff} != DEPTH_24) begin
                     header_error = 1'b1;
                     error_status = STATUS_BAD_DEPTH;
                  end else if (width_cur > DIM_LIMIT || height_cur > DIM_LIMIT) begin
                     header_error = 1'b1;
                     error_status = STATUS_TOO_LARGE;
                  end
               end
               if (header_error) begin
                  phase_in            = PH_IDLE;
                  write_in.push       = 1'b1;
                  write_in.item       = '0;
                  write_in.item.status = error_status;
               end else if (pos_cur == POS_W'(HEADER_BYTES - 1)) begin
                  phase_in = (width_cur == '0 || height_cur == '0) ? PH_IDLE : PH_PIXELS;
               end
            end
            PH_PIXELS: begin
               case (chan_cur)
                  2'd0: begin
                     blue_in = byte_value;
                     chan_in = 2'd1;
                  end
                  2'd1: begin
                     green_in = byte_value;
                     chan_in  = 2'd2;
                  end
                  default: begin
                     chan_in = 2'd0;
                     write_in.push              = 1'b1;
                     write_in.item.red          = byte_value;
                     write_in.item.green        = green_ff;
                     write_in.item.blue         = blue_ff;
                     write_in.item.pixel_column = col_cur[COORD_W-1:0];
                     write_in.item.pixel_row    = row_cur[COORD_W-1:0];
                     write_in.item.last_pixel   = is_last;
                     write_in.item.status       = STATUS_PIXEL;
                     if (is_last) begin
                        phase_in = PH_IDLE;
                     end else if (col_next >= width_cur[CNT_W-1:0]) begin
                        col_in   = '0;
                        row_in   = row_next;
                        pad_in   = width_cur[1:0];
                        phase_in = (width_cur[1:0] != 2'd0) ? PH_PADDING : PH_PIXELS;
                     end else begin
                        col_in = col_next;
                     end
                  end
               endcase
            end
            PH_PADDING: begin
               pad_in = pad_cur - 1'b1;
               if (pad_cur == 2'd1) begin
                  phase_in = PH_PIXELS;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         pos_ff      <= '0;
         letter_ff   <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         depth_lo_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         chan_ff     <= '0;
         blue_ff     <= '0;
         green_ff    <= '0;
         pad_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         letter_ff   <= letter_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         depth_lo_ff <= depth_lo_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         chan_ff     <= chan_in;
         blue_ff     <= blue_in;
         green_ff    <= green_in;
         pad_ff      <= pad_in;
      end
   end

   assign queue_write = write_in;

endmodule : bmpdec_front
`default_nettype wire

// ----- rtl/bmpdec_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmpdec_queue
// Back end of the decoder. A two-entry result queue whose head entry drives
// the result channel, so the parser keeps taking bytes while a result waits.
// ----------------------------------------------------------------------------
module bmpdec_queue
   import bmpdec_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire queue_write_type queue_write,
   output logic           full,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_item_type   rsp_item
);

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

   rsp_item_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push;
   logic               pop;

   assign push      = queue_write.push;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign full      = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign rsp_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= queue_write.item;
      end
   end

endmodule : bmpdec_queue
`default_nettype wire

// ----- rtl/bmp24_stream_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bmp24_stream_decoder
// Decodes a 24-bit BMP file delivered one byte per item into pixel items.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock cycle while req_stall is low.
// Each accepted byte is parsed in the cycle of its acceptance, and any
// result item it causes is registered into the result queue and appears
// on the result channel once it reaches the head of the queue. Results
// pass through a two-entry queue, so req_stall rises only when two results
// are waiting to be collected; each pixel item is built from three bytes.
// The header occupies the first 54 bytes; bad signature, wrong depth or an
// oversize image give a single error item, and then bytes are dropped until
// the next byte that carries req_start_of_file.
// ----------------------------------------------------------------------------
module bmp24_stream_decoder
   import bmpdec_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [BYTE_W-1:0]  req_byte_value,
   input  wire logic               req_start_of_file,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [BYTE_W-1:0]       rsp_red,
   output logic [BYTE_W-1:0]       rsp_green,
   output logic [BYTE_W-1:0]       rsp_blue,
   output logic [COORD_W-1:0]      rsp_pixel_column,
   output logic [COORD_W-1:0]      rsp_pixel_row,
   output logic                    rsp_last_pixel,
   output logic [1:0]              rsp_status
);

   queue_write_type queue_write;
   rsp_item_type    rsp_item;
   logic            queue_full;
   logic            accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   bmpdec_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .start_of_file (req_start_of_file),
      .queue_write   (queue_write)
   );

   bmpdec_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .queue_write (queue_write),
      .full        (queue_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

   assign rsp_red          = rsp_item.red;
   assign rsp_green        = rsp_item.green;
   assign rsp_blue         = rsp_item.blue;
   assign rsp_pixel_column = rsp_item.pixel_column;
   assign rsp_pixel_row    = rsp_item.pixel_row;
   assign rsp_last_pixel   = rsp_item.last_pixel;
   assign rsp_status       = rsp_item.status;

endmodule : bmp24_stream_decoder
`default_nettype wire
